FILE: design/mps_pkg.sv
// shared types and constants for the multi-axis position stepper
`timescale 1ns / 1ps
`default_nettype none
package mps_pkg;

  localparam int AXES_DEF = 4;
  localparam int MAX_REPORT = 4;

  localparam int POS_W = 32;
  localparam int SPD_W = 21;
  localparam int TICK_W = 10;
  localparam int RATE_W = 20;
  localparam int CODE_W = 16;
  localparam int DIV_W = 30;
  localparam int STEP_W = 21;
  localparam int PROD_W = 43;

  // floor(x / 1000) as (x * RECIP_1000) >> RECIP_SH, exact for x below 2^DIV_W
  localparam int RECIP_W = 29;
  localparam int RECIP_SH = 38;
  localparam int RPROD_W = DIV_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [TICK_W-1:0] MS_PER_S = 10'd1000;

  localparam logic [TICK_W-1:0] TICK_MS_RST = 10'd10;
  localparam logic [RATE_W-1:0] TOP_RATE_RST = 20'd100000;
  localparam logic [RATE_W-1:0] HOME_SPEED_RST = 20'd50000;
  localparam logic [CODE_W-1:0] ENABLE_MASK_RST = 16'd1;
  localparam logic [CODE_W-1:0] HOME_CODE_RST = 16'd1;

  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] STAT_ENABLED = 2'd3;
  localparam logic [1:0] STAT_STANDBY = 2'd2;
  localparam logic [1:0] HOME_NONE = 2'd0;
  localparam logic [1:0] HOME_BUSY = 2'd1;
  localparam logic [1:0] HOME_FINISHED = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_MS    = 3'd0,
    REG_TOP_RATE   = 3'd1,
    REG_HOME_SPEED = 3'd2,
    REG_ENABLE_MSK = 3'd3,
    REG_HOME_CODE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic [RATE_W-1:0] top_rate;
    logic [RATE_W-1:0] home_speed;
    logic [CODE_W-1:0] enable_mask;
    logic [CODE_W-1:0] home_start_code;
  } cfg_t;

  typedef struct packed {
    logic             tick;
    logic [3:0]       axis;
    logic             en;
    logic             home_go;
    logic [POS_W-1:0] target;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_TK_MUL,
    ST_TK_HSTEP,
    ST_TK_MSTEP,
    ST_AX_A,
    ST_AX_B,
    ST_AX_DIV,
    ST_EMIT
  } st_t;

endpackage
`default_nettype wire

FILE: design/mps_if.sv
// channel interfaces for items, results and configuration writes
`timescale 1ns / 1ps
`default_nettype none
interface mps_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  axis;
  logic [15:0] ctrl_bits;
  logic [15:0] home_req;
  logic [31:0] goal_pos;
  modport source (output valid, kind, axis, ctrl_bits, home_req, goal_pos,
                  input ready);
  modport sink (input valid, kind, axis, ctrl_bits, home_req, goal_pos,
                output ready);
endinterface

interface mps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  axis_index;
  logic [1:0]  axis_state;
  logic [1:0]  homing_state;
  logic [31:0] position;
  logic [20:0] speed;
  logic        last;
  modport source (output valid, axis_index, axis_state, homing_state, position, speed, last,
                  input ready);
  modport sink (input valid, axis_index, axis_state, homing_state, position, speed, last,
                output ready);
endinterface

interface mps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/mps_div.sv
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mps_div
  import mps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [TICK_W-1:0] divisor,
  output logic                   done,
  output logic [DIV_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  dvd;
  logic [TICK_W-1:0] rem;
  logic [TICK_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [TICK_W:0]   rem_sh;
  logic              qbit;

  assign rem_sh = {rem, dvd[DIV_W-1]};
  assign qbit = rem_sh >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
      end else if (busy) begin
        rem <= qbit ? TICK_W'(rem_sh - {1'b0, dsr}) : rem_sh[TICK_W-1:0];
        dvd <= {dvd[DIV_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/mps_front.sv
// input side: classifies items and queues them for the axis engine
`timescale 1ns / 1ps
`default_nettype none
module mps_front
  import mps_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  mps_in_if.sink    in_ch,
  input  wire cfg_t cfg,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_data
);

  cmd_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       acc;
  logic       drop;
  cmd_t       cls;

  assign in_ch.ready = cnt != 2'd2;
  assign acc = in_ch.valid && in_ch.ready;
  assign drop = (in_ch.kind == KIND_CMD) && (5'(in_ch.axis) >= 5'(AXES));
  assign q_valid = cnt != 2'd0;
  assign q_data = entry[rptr];

  always_comb begin
    cls.tick = in_ch.kind == KIND_TICK;
    cls.axis = 4'(in_ch.axis);
    cls.en = (in_ch.ctrl_bits & cfg.enable_mask) != '0;
    cls.home_go = in_ch.home_req == cfg.home_start_code;
    cls.target = in_ch.goal_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt <= '0;
    end else begin
      if (acc && !drop) begin
        entry[wptr] <= cls;
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      cnt <= cnt + 2'(acc && !drop) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/mps_back.sv
// axis engine: applies commands, steps axes on ticks, reports status
`timescale 1ns / 1ps
`default_nettype none
module mps_back
  import mps_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic q_valid,
  input  wire cmd_t q_data,
  output logic      pop,
  mps_out_if.source out_ch
);

  localparam int AW = AXES > 1 ? $clog2(AXES) : 1;
  localparam int REPORT = AXES < MAX_REPORT ? AXES : MAX_REPORT;

  st_t state, state_next;

  logic [AXES-1:0] enabled;
  logic [AXES-1:0] homing;
  logic [AXES-1:0] homed;
  logic [POS_W-1:0] tgt_r [AXES];
  logic [POS_W-1:0] pos_r [AXES];
  logic [SPD_W-1:0] spd_r [AXES];

  logic [AW-1:0]     cur;
  logic              single;
  logic              c_en;
  logic              c_home;
  logic [POS_W-1:0]  c_target;
  logic [DIV_W-1:0]  reach;
  logic [DIV_W-1:0]  hprod;
  logic [STEP_W-1:0] hstep;
  logic [STEP_W-1:0] mstep;
  logic [PROD_W-1:0] prod;
  logic              dneg;
  logic              dzero;
  logic              ov;
  logic [DIV_W-1:0]  rin;
  logic [RPROD_W-1:0] rprod;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [TICK_W-1:0] div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;

  logic [POS_W-1:0]  pos_c;
  logic [POS_W-1:0]  tgt_c;
  logic [POS_W:0]    d;
  logic [POS_W:0]    mag;
  logic              far;
  logic              last_axis;
  logic              out_free;
  logic              emit_last;
  logic [POS_W:0]    h_dn;
  logic [POS_W:0]    h_up;
  logic [POS_W:0]    m_sum;
  logic [SPD_W-1:0]  hs_s;
  logic [SPD_W-1:0]  ms_s;
  logic              en_a;
  logic              hom_a;
  logic              hom_b;

  mps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign pos_c = pos_r[cur];
  assign tgt_c = tgt_r[cur];
  assign d = {tgt_c[POS_W-1], tgt_c} - {pos_c[POS_W-1], pos_c};
  assign mag = d[POS_W] ? (POS_W+1)'(0) - d : d;
  assign far = (prod > PROD_W'(reach)) || (cfg.tick_ms == '0);
  assign last_axis = cur == AW'(AXES - 1);
  assign out_free = !ov || out_ch.ready;
  assign emit_last = single || (cur == AW'(REPORT - 1));
  assign h_dn = {pos_c[POS_W-1], pos_c} - (POS_W+1)'(hstep);
  assign h_up = {pos_c[POS_W-1], pos_c} + (POS_W+1)'(hstep);
  assign m_sum = dneg ? {pos_c[POS_W-1], pos_c} - (POS_W+1)'(mstep)
                      : {pos_c[POS_W-1], pos_c} + (POS_W+1)'(mstep);
  assign hs_s = {1'b0, cfg.home_speed};
  assign ms_s = {1'b0, cfg.top_rate};

  // step length per tick: product over 1000 by reciprocal multiply
  assign rin = (state == ST_TK_HSTEP) ? hprod : reach;
  assign rprod = RPROD_W'(rin) * RPROD_W'(RECIP_1000);

  // command effect on the addressed axis
  always_comb begin
    en_a = enabled[cur];
    hom_a = homing[cur];
    if (c_en && !enabled[cur]) begin
      en_a = 1'b1;
    end else if (!c_en && enabled[cur]) begin
      en_a = 1'b0;
      hom_a = 1'b0;
    end
    hom_b = hom_a || c_home;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    div_start = 1'b0;
    div_dividend = prod[DIV_W-1:0];
    div_divisor = cfg.tick_ms;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          state_next = q_data.tick ? ST_TK_MUL : ST_CMD;
        end
      end
      ST_CMD: state_next = ST_EMIT;
      ST_TK_MUL: state_next = ST_TK_HSTEP;
      ST_TK_HSTEP: state_next = ST_TK_MSTEP;
      ST_TK_MSTEP: state_next = ST_AX_A;
      ST_AX_A: state_next = ST_AX_B;
      ST_AX_B: begin
        if (!homing[cur] && enabled[cur] && !dzero && !far) begin
          div_start = 1'b1;
          state_next = ST_AX_DIV;
        end else begin
          state_next = last_axis ? ST_EMIT : ST_AX_A;
        end
      end
      ST_AX_DIV: if (div_done) state_next = last_axis ? ST_EMIT : ST_AX_A;
      ST_EMIT: if (out_free && emit_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
      homing <= '0;
      homed <= '0;
      ov <= 1'b0;
      cur <= '0;
      single <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        tgt_r[i] <= '0;
        pos_r[i] <= '0;
        spd_r[i] <= '0;
      end
    end else begin
      ov <= (state == ST_EMIT && out_free) || (ov && !out_ch.ready);
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_data.tick ? '0 : AW'(q_data.axis);
            single <= !q_data.tick;
            c_en <= q_data.en;
            c_home <= q_data.home_go;
            c_target <= q_data.target;
          end
        end
        ST_CMD: begin
          enabled[cur] <= en_a;
          homing[cur] <= hom_b;
          if (!hom_a && c_home) begin
            homed[cur] <= 1'b0;
          end
          if (!c_en && enabled[cur]) begin
            spd_r[cur] <= '0;
          end
          if (en_a && !hom_b) begin
            tgt_r[cur] <= c_target;
          end
        end
        ST_TK_MUL: begin
          reach <= DIV_W'(cfg.top_rate) * DIV_W'(cfg.tick_ms);
          hprod <= DIV_W'(cfg.home_speed) * DIV_W'(cfg.tick_ms);
        end
        ST_TK_HSTEP: hstep <= rprod[RECIP_SH +: STEP_W];
        ST_TK_MSTEP: mstep <= rprod[RECIP_SH +: STEP_W];
        ST_AX_A: begin
          prod <= PROD_W'(mag) * PROD_W'(MS_PER_S);
          dneg <= d[POS_W];
          dzero <= d == '0;
        end
        ST_AX_B: begin
          if (homing[cur]) begin
            if (!pos_c[POS_W-1] && pos_c != '0) begin
              spd_r[cur] <= SPD_W'(0) - hs_s;
              pos_r[cur] <= h_dn[POS_W] ? '0 : h_dn[POS_W-1:0];
            end else if (pos_c[POS_W-1]) begin
              spd_r[cur] <= hs_s;
              pos_r[cur] <= (!h_up[POS_W] && h_up != '0) ? '0 : h_up[POS_W-1:0];
            end else begin
              homing[cur] <= 1'b0;
              homed[cur] <= 1'b1;
              spd_r[cur] <= '0;
            end
          end else if (enabled[cur]) begin
            if (dzero) begin
              spd_r[cur] <= '0;
            end else if (far) begin
              spd_r[cur] <= dneg ? SPD_W'(0) - ms_s : ms_s;
              if (m_sum[POS_W] != m_sum[POS_W-1]) begin
                pos_r[cur] <= m_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                           : {1'b0, {(POS_W-1){1'b1}}};
              end else begin
                pos_r[cur] <= m_sum[POS_W-1:0];
              end
            end
          end else begin
            spd_r[cur] <= '0;
          end
          if (homing[cur] || !enabled[cur] || dzero || far) begin
            cur <= last_axis ? '0 : cur + 1'b1;
          end
        end
        ST_AX_DIV: begin
          if (div_done) begin
            spd_r[cur] <= dneg ? SPD_W'(0) - SPD_W'(div_q) : SPD_W'(div_q);
            pos_r[cur] <= tgt_c;
            cur <= last_axis ? '0 : cur + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_ch.axis_index <= 2'(cur);
            out_ch.axis_state <= enabled[cur] ? STAT_ENABLED : STAT_STANDBY;
            out_ch.homing_state <= homing[cur] ? HOME_BUSY
                                 : (homed[cur] ? HOME_FINISHED : HOME_NONE);
            out_ch.position <= pos_c;
            out_ch.speed <= spd_r[cur];
            out_ch.last <= emit_last;
            if (!emit_last) begin
              cur <= cur + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = ov;

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_AX_DIV)
    else $error("divider finished outside a wait state");

  a_home_flags: assert property (@(posedge clk) disable iff (rst)
    (homing & homed) == '0)
    else $error("axis both homing and homed");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE && q_valid)
    else $error("queue popped while engine busy");

  a_reset: assert property (@(posedge clk)
    rst |=> state == ST_IDLE && !ov)
    else $error("engine not idle after reset");

endmodule
`default_nettype wire

FILE: design/multi_axis_position_stepper.sv
// top level of the multi-axis position stepper
`timescale 1ns / 1ps
`default_nettype none
// Keeps AXES motion axes. A command beat updates one axis and returns one
// status beat; a command to an axis beyond AXES is taken and dropped. A
// tick beat steps every axis and returns the status of the first AXES axes,
// at most four (axes 0 to 3), the final one flagged last. A tick first works
// out the homing and tracking step lengths (a multiply step, then a
// reciprocal multiply for each division by 1000), then steps each axis in
// turn; an axis that lands on its target waits for its speed from the serial
// divider, one quotient bit a cycle, and then the status beats follow. A two
// entry input queue keeps taking beats while the axis engine works, until it
// is full, and the result register holds a beat while the next is prepared.
module multi_axis_position_stepper
  import mps_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  mps_in_if.sink    in_ch,
  mps_out_if.source out_ch,
  mps_cfg_if.sink   cfg_ch
);

  cfg_t cfg;
  logic q_valid;
  cmd_t q_data;
  logic pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_ms <= TICK_MS_RST;
      cfg.top_rate <= TOP_RATE_RST;
      cfg.home_speed <= HOME_SPEED_RST;
      cfg.enable_mask <= ENABLE_MASK_RST;
      cfg.home_start_code <= HOME_CODE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_TICK_MS: cfg.tick_ms <= cfg_ch.data[TICK_W-1:0];
        REG_TOP_RATE: cfg.top_rate <= cfg_ch.data[RATE_W-1:0];
        REG_HOME_SPEED: cfg.home_speed <= cfg_ch.data[RATE_W-1:0];
        REG_ENABLE_MSK: cfg.enable_mask <= cfg_ch.data[CODE_W-1:0];
        REG_HOME_CODE: cfg.home_start_code <= cfg_ch.data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  mps_front #(.AXES(AXES)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .pop     (pop),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  mps_back #(.AXES(AXES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
